[src/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants for the chained hash map core.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int DEF_BUCKETS = 256;
   localparam int DEF_ENTRIES = 1024;

   localparam int KEY_W = 20;
   localparam int VAL_W = 20;
   localparam int RV_W  = 21;
   localparam int OP_W  = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [RV_W-1:0] RV_ABSENT = {RV_W{1'b1}};

endpackage

[src/chained_hash_map_core.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_core
// Key-value map with separate chaining over a node pool held in RAM.
//
// Channel   Ports        Contents (low bit first)
// request   req_t*       op[1:0], lookup_key[21:2], new_value[41:22], zero pad
// response  rsp_t*       read_value[20:0], hit[21], pool_full[22], zero pad
//
// A request passes through the modulo unit, a bucket head read, a check and a
// compare per chain node walked, then a final action; an allocation or unlink
// adds a step. Unused ops go straight to the response. After reset a clearing
// pass runs first: bucket heads are set empty and the pool becomes a free list.
// A response waiting on rsp_tready holds the next request in its ST_FIN state.
// ----------------------------------------------------------------------------
module chained_hash_map_core
   import chm_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op, lookup_key, new_value, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_value, hit, pool_full, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PW   = $clog2(ENTRIES + 1);
   localparam int MAXD = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
   localparam int CW   = $clog2(MAXD + 1);
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);

   typedef enum logic [10:0] {
      ST_INIT  = 11'b00000000001,
      ST_IDLE  = 11'b00000000010,
      ST_MOD   = 11'b00000000100,
      ST_HEAD  = 11'b00000001000,
      ST_HCAP  = 11'b00000010000,
      ST_CHECK = 11'b00000100000,
      ST_CMP   = 11'b00001000000,
      ST_ACT   = 11'b00010000000,
      ST_ALLOC = 11'b00100000000,
      ST_REM2  = 11'b01000000000,
      ST_FIN   = 11'b10000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [PW-1:0]     free_ff, free_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [BW-1:0]     bkt_ff, bkt_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [PW-1:0]     cur_ff, cur_in;
   logic [PW-1:0]     prev_ff, prev_in;
   logic [PW-1:0]     next_ff, next_in;
   logic [PW-1:0]     steps_ff, steps_in;
   logic [VAL_W-1:0]  vrd_ff, vrd_in;
   logic              found_ff, found_in;
   logic [RV_W-1:0]   rv_ff, rv_in;
   logic              hit_ff, hit_in;
   logic              full_ff, full_in;

   logic              mod_start, mod_done;
   logic [BW-1:0]     mod_rem;

   logic              bkt_we;
   logic [BW-1:0]     bkt_waddr, bkt_raddr;
   logic [PW-1:0]     bkt_wdata, bkt_rdata;
   logic              link_we;
   logic [AW-1:0]     link_waddr, link_raddr;
   logic [PW-1:0]     link_wdata, link_rdata;
   logic              key_we;
   logic [AW-1:0]     node_waddr, node_raddr;
   logic [KEY_W-1:0]  key_rdata;
   logic              val_we;
   logic [AW-1:0]     val_waddr;
   logic [VAL_W-1:0]  val_rdata;
   logic              req_fire;
   logic [CW-1:0]     cnt_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign cnt_next   = cnt_ff + 1'b1;

   chm_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (key_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   chm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bkt_ram (
      .clock (clock), .we (bkt_we), .waddr (bkt_waddr), .wdata (bkt_wdata),
      .raddr (bkt_raddr), .rdata (bkt_rdata)
   );

   chm_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
      .clock (clock), .we (link_we), .waddr (link_waddr), .wdata (link_wdata),
      .raddr (link_raddr), .rdata (link_rdata)
   );

   chm_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock (clock), .we (key_we), .waddr (node_waddr), .wdata (key_ff),
      .raddr (node_raddr), .rdata (key_rdata)
   );

   chm_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock (clock), .we (val_we), .waddr (val_waddr), .wdata (val_ff),
      .raddr (node_raddr), .rdata (val_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      bkt_in       = bkt_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      steps_in     = steps_ff;
      vrd_in       = vrd_ff;
      found_in     = found_ff;
      rv_in        = rv_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      mod_start    = 1'b0;
      bkt_we       = 1'b0;
      bkt_waddr    = bkt_ff;
      bkt_wdata    = next_ff;
      bkt_raddr    = bkt_ff;
      link_we      = 1'b0;
      link_waddr   = prev_ff[AW-1:0];
      link_wdata   = next_ff;
      link_raddr   = cur_ff[AW-1:0];
      key_we       = 1'b0;
      val_we       = 1'b0;
      node_waddr   = free_ff[AW-1:0];
      node_raddr   = cur_ff[AW-1:0];
      val_waddr    = free_ff[AW-1:0];

      unique case (state_ff)
         ST_INIT: begin
            bkt_we     = (cnt_ff < CW'(BUCKETS));
            bkt_waddr  = cnt_ff[BW-1:0];
            bkt_wdata  = NIL;
            link_we    = (cnt_ff < CW'(ENTRIES));
            link_waddr = cnt_ff[AW-1:0];
            link_wdata = cnt_next[PW-1:0];
            cnt_in     = cnt_next;
            if (cnt_ff == CW'(MAXD - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_tdata[OP_W-1:0];
               key_in  = req_tdata[OP_W+KEY_W-1:OP_W];
               val_in  = req_tdata[OP_W+KEY_W+VAL_W-1:OP_W+KEY_W];
               rv_in   = RV_ABSENT;
               hit_in  = 1'b0;
               full_in = 1'b0;
               if (req_tdata[OP_W-1:0] == OP_PUT || req_tdata[OP_W-1:0] == OP_GET ||
                   req_tdata[OP_W-1:0] == OP_REMOVE) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MOD: begin
            mod_start = (cnt_ff == '0);
            cnt_in    = '1;
            if (mod_done) begin
               bkt_in   = mod_rem;
               cnt_in   = '0;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = ST_HCAP;
         end
         ST_HCAP: begin
            head_in  = bkt_rdata;
            cur_in   = bkt_rdata;
            prev_in  = NIL;
            steps_in = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cur_ff >= NIL || steps_ff == NIL) begin
               found_in = 1'b0;
               state_in = ST_ACT;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (key_rdata == key_ff) begin
               found_in = 1'b1;
               next_in  = link_rdata;
               vrd_in   = val_rdata;
               state_in = ST_ACT;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               steps_in = steps_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_ACT: begin
            hit_in   = found_ff;
            state_in = ST_FIN;
            case (op_ff)
               OP_PUT: begin
                  if (found_ff) begin
                     val_we    = 1'b1;
                     val_waddr = cur_ff[AW-1:0];
                  end else if (free_ff != NIL) begin
                     link_raddr = free_ff[AW-1:0];
                     state_in   = ST_ALLOC;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               OP_GET: begin
                  if (found_ff) begin
                     rv_in = {1'b0, vrd_ff};
                  end
               end
               OP_REMOVE: begin
                  if (found_ff) begin
                     if (prev_ff != NIL) begin
                        link_we = 1'b1;
                     end else begin
                        bkt_we = 1'b1;
                     end
                     state_in = ST_REM2;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_ALLOC: begin
            free_in    = link_rdata;
            key_we     = 1'b1;
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_waddr = free_ff[AW-1:0];
            link_wdata = head_ff;
            bkt_we     = 1'b1;
            bkt_wdata  = free_ff;
            state_in   = ST_FIN;
         end
         ST_REM2: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[AW-1:0];
            link_wdata = free_ff;
            free_in    = cur_ff;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({full_ff, hit_ff, rv_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      bkt_ff      <= bkt_in;
      head_ff     <= head_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      next_ff     <= next_in;
      steps_ff    <= steps_in;
      vrd_ff      <= vrd_in;
      found_ff    <= found_in;
      rv_ff       <= rv_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
   end

endmodule

[src/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/chm_mod.sv]
// ----------------------------------------------------------------------------
// chm_mod
// Remainder unit: key modulo BUCKETS by reciprocal multiplication pipelined
// through prod_ff, diff_ff and rem_ff; one compare and subtract fixes the estimate.
// ----------------------------------------------------------------------------
module chm_mod
   import chm_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
   localparam int MW = KEY_W + 1,
   localparam int PRODW = KEY_W + MW,
   localparam int RW = BW + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] dividend,
   output logic             done,
   output logic [BW-1:0]    remainder
);

   // The quotient estimate is low by at most one, so the raw remainder lies
   // below twice the divisor and fits in BW+1 bits.
   localparam logic [MW-1:0] RECIP = MW'((longint'(1) << KEY_W) / longint'(BUCKETS));
   localparam logic [RW-1:0] DIV_R = RW'(BUCKETS);

   logic             s1_ff, s2_ff, done_ff;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [PRODW-1:0] prod_ff, prod_in;
   logic [RW-1:0]    diff_ff, diff_in;
   logic [BW-1:0]    rem_ff, rem_in;
   logic [MW-1:0]    quot;
   logic [RW-1:0]    prod_lo;
   logic [RW-1:0]    fixed;

   always_comb begin
      key_in  = start ? dividend : key_ff;
      prod_in = PRODW'(dividend) * PRODW'(RECIP);
      quot    = prod_ff[PRODW-1:KEY_W];
      prod_lo = quot[RW-1:0] * DIV_R;
      diff_in = key_ff[RW-1:0] - prod_lo;
      fixed   = (diff_ff >= DIV_R) ? (diff_ff - DIV_R) : diff_ff;
      rem_in  = fixed[BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[src/chm_checker.sv]
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks for the chained hash map core, bound to the top level.
// ----------------------------------------------------------------------------
module chm_checker
   import chm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [RV_W-1:0] rv;
   logic            hit;
   logic            full;

   assign rv   = rsp_tdata[RV_W-1:0];
   assign hit  = rsp_tdata[RV_W];
   assign full = rsp_tdata[RV_W+1];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Response changed while stalled.");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Core ready right after taking a request.");

   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && full |-> !hit && rv == RV_ABSENT)
      else $error("Pool full reported together with a hit or a value.");

   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rv != RV_ABSENT |-> hit && !rv[RV_W-1])
      else $error("Value returned without a hit.");

endmodule

bind chained_hash_map_core chm_checker u_chm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/chained_hash_map_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_map_core_tb
// Self-checking bench for the chained hash map core. A scoreboard keeps its
// own bucket chains, node pool and free list, predicts the response to every
// accepted request and compares each response field by field. Stimulus fills
// the pool past its capacity, then mixes puts, gets and removes under several
// patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module chained_hash_map_core_tb;
   import chm_pkg::*;

   localparam int NBUCKET = DEF_BUCKETS;
   localparam int NNODE   = DEF_ENTRIES;
   localparam logic [10:0] NODE_NIL = 11'(NNODE);
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int NKEYS = 1100;

   typedef struct packed {
      logic [RV_W-1:0] read_value;
      logic            hit;
      logic            pool_full;
   } map_rsp_type;

   class map_scoreboard;
      logic [10:0]      head_of[NBUCKET];
      logic [KEY_W-1:0] key_of[NNODE];
      logic [VAL_W-1:0] val_of[NNODE];
      logic [10:0]      link_of[NNODE];
      logic [10:0]      free_top;
      map_rsp_type      pending_rsp[$];
      int               errors;
      int               n_checked;
      int               n_full;

      function new();
         for (int i = 0; i < NBUCKET; i++) head_of[i] = NODE_NIL;
         for (int i = 0; i < NNODE; i++) link_of[i] = 11'(i + 1);
         free_top = 0;
         errors = 0;
         n_checked = 0;
         n_full = 0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] val);
         map_rsp_type r;
         logic [10:0] prev, cur, n;
         int b, steps;
         r.read_value = RV_ABSENT;
         r.hit = 0;
         r.pool_full = 0;
         if (op != OP_UNUSED) begin
            b = key % NBUCKET;
            prev = NODE_NIL;
            cur = head_of[b];
            steps = 0;
            while (cur != NODE_NIL && steps < NNODE && key_of[cur] != key) begin
               prev = cur;
               cur = link_of[cur];
               steps++;
            end
            if (steps >= NNODE) cur = NODE_NIL;
            r.hit = (cur != NODE_NIL);
            if (op == OP_PUT) begin
               if (r.hit) begin
                  val_of[cur] = val;
               end else if (free_top != NODE_NIL) begin
                  n = free_top;
                  free_top = link_of[n];
                  key_of[n] = key;
                  val_of[n] = val;
                  link_of[n] = head_of[b];
                  head_of[b] = n;
               end else begin
                  r.pool_full = 1;
               end
            end else if (op == OP_GET) begin
               if (r.hit) r.read_value = {1'b0, val_of[cur]};
            end else if (r.hit) begin
               if (prev != NODE_NIL) link_of[prev] = link_of[cur];
               else head_of[b] = link_of[cur];
               link_of[cur] = free_top;
               free_top = cur;
            end
         end
         pending_rsp.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_response(logic [RSP_TDATA_W-1:0] data);
         map_rsp_type w;
         if (pending_rsp.size() == 0) begin
            report("unexpected response", 32'(data), 0);
            return;
         end
         w = pending_rsp.pop_front();
         n_checked++;
         if (w.pool_full) n_full++;
         if (data[20:0] !== w.read_value) report("read_value", 32'(data[20:0]), 32'(w.read_value));
         if (data[21] !== w.hit) report("hit", 32'(data[21]), 32'(w.hit));
         if (data[22] !== w.pool_full) report("pool_full", 32'(data[22]), 32'(w.pool_full));
         if (data[23] !== 1'b0) report("pad", 32'(data[23]), 0);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   map_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   int hold_cycles = 0;
   int n_sent = 0;
   logic [KEY_W-1:0] key_pool[NKEYS];

   chained_hash_map_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #4ms;
      $display("Timeout");
      $display("Some tests failed");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready <= 0;
         end else if (hold_cycles > 0) begin
            rsp_tready <= 0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // Called at a falling edge; returns at a falling edge after acceptance.
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] val);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, val, key, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, key, val);
      n_sent++;
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 80) return key_pool[$urandom_range(NKEYS - 1)];
      return KEY_W'($urandom);
   endfunction

   task automatic mixed_requests(int count);
      int r;
      logic [OP_W-1:0] op;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         op = (r < 35) ? OP_PUT : (r < 70) ? OP_GET : (r < 95) ? OP_REMOVE : OP_UNUSED;
         send_request(op, pick_key(), VAL_W'($urandom));
      end
   endtask

   task automatic fill_requests(int first, int last);
      for (int i = first; i < last; i++) begin
         if ($urandom_range(9) == 0)
            send_request(OP_GET, pick_key(), VAL_W'($urandom));
         send_request(OP_PUT, key_pool[i], VAL_W'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < NKEYS; i++) key_pool[i] = KEY_W'($urandom);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      send_request(OP_GET, 20'd0, 20'hFFFFF);
      send_request(OP_PUT, 20'd0, 20'd0);
      send_request(OP_PUT, 20'hFFFFF, 20'hFFFFF);
      send_request(OP_GET, 20'd0, 20'd0);
      send_request(OP_GET, 20'hFFFFF, 20'd0);
      send_request(OP_PUT, 20'hFFFFF, 20'h5A5A5);
      send_request(OP_GET, 20'hFFFFF, 20'hFFFFF);
      send_request(OP_PUT, 20'd5, 20'd11);
      send_request(OP_PUT, 20'd261, 20'd22);
      send_request(OP_PUT, 20'd517, 20'd33);
      send_request(OP_REMOVE, 20'd261, 20'hFFFFF);
      send_request(OP_GET, 20'd5, 20'd0);
      send_request(OP_GET, 20'd517, 20'd0);
      send_request(OP_GET, 20'd261, 20'd0);
      send_request(OP_REMOVE, 20'd261, 20'd0);
      send_request(OP_REMOVE, 20'd517, 20'd0);
      send_request(OP_UNUSED, 20'hFFFFF, 20'hFFFFF);
      send_request(OP_UNUSED, 20'd0, 20'd0);
      send_request(OP_GET, 20'd517, 20'd0);

      fill_requests(0, 550);
      send_idle = 80;
      fill_requests(550, NKEYS);
      send_request(OP_PUT, 20'h12345, 20'h54321);
      send_idle = 0;
      recv_stall = 80;
      hold_cycles = 400;
      mixed_requests(60);
      send_idle = 37;
      recv_stall = 37;
      mixed_requests(60);
      req_tvalid <= 0;

      while (sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests and %0d responses, %0d of them refused for a full pool.",
               n_sent, sb.n_checked, sb.n_full);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
